// ===== hw/rtl/best_fit_normal_length_search_core_defines.svh =====
// assertion helpers for the normal length search core
`ifndef BEST_FIT_NORMAL_LENGTH_SEARCH_CORE_DEFINES_SVH
`define BEST_FIT_NORMAL_LENGTH_SEARCH_CORE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define BFNL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define BFNL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bfnl_pkg.sv =====
package bfnl_pkg;

  localparam int unsigned IN_W            = 16;
  localparam int unsigned MAG_W           = 16;
  localparam int unsigned Q_W             = 17;
  localparam int unsigned NUM_W           = 18;
  localparam int unsigned ERR_W           = 17;
  localparam int unsigned STEP_W          = 7;
  localparam int unsigned CODE_W          = 8;
  localparam int unsigned NUM_LANES       = 3;
  localparam int unsigned RECIP_SHIFT     = 28;
  localparam int unsigned RECIP_W         = 26;
  localparam int unsigned PROD_W          = RECIP_SHIFT + ERR_W;
  localparam int unsigned PROBE_STEPS_DEF = 127;

  localparam logic [Q_W-1:0]    Q_ONE       = 17'h10000;
  localparam logic [CODE_W-1:0] ZERO_CODE   = 8'd255;
  localparam logic [STEP_W-1:0] ZERO_STEP   = 7'd127;

  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [Q_W-1:0]   sh;
    logic             neg;
  } div_lane_t;

  typedef struct packed {
    logic                            valid;
    logic                            zero;
    logic [MAG_W-1:0]                m;
    div_lane_t [NUM_LANES-1:0]       lane;
  } div_bus_t;

  typedef struct packed {
    logic                            valid;
    logic                            zero;
    logic [NUM_LANES-1:0][Q_W-1:0]   n;
    logic [NUM_LANES-1:0][Q_W-1:0]   l;
    logic [ERR_W-1:0]                best_err;
    logic [STEP_W-1:0]               best_step;
  } probe_bus_t;

  typedef struct packed {
    logic                            valid;
    logic                            zero;
    logic [NUM_LANES-1:0][Q_W-1:0]   n;
    logic [NUM_LANES-1:0][Q_W-1:0]   l;
    logic [NUM_LANES-1:0][NUM_W-1:0] num;
    logic [ERR_W-1:0]                best_err;
    logic [STEP_W-1:0]               best_step;
  } probe_mid_t;

endpackage

// ===== hw/rtl/bfnl_div_stage.sv =====
module bfnl_div_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  bfnl_pkg::div_bus_t in_i,
  output bfnl_pkg::div_bus_t out_o
);

  logic [bfnl_pkg::NUM_LANES-1:0][bfnl_pkg::MAG_W:0] trial;
  logic [bfnl_pkg::NUM_LANES-1:0]                    fits;
  bfnl_pkg::div_bus_t data_d, data_q;
  logic               valid_q;

  // one quotient bit per lane per stage
  for (genvar k = 0; k < bfnl_pkg::NUM_LANES; k++) begin : g_lane
    assign trial[k] = {in_i.lane[k].rem, in_i.lane[k].sh[bfnl_pkg::Q_W-1]};
    assign fits[k]  = trial[k] >= {1'b0, in_i.m};
  end

  always_comb begin
    data_d = in_i;
    for (int k = 0; k < bfnl_pkg::NUM_LANES; k++) begin
      data_d.lane[k].rem = fits[k] ? bfnl_pkg::MAG_W'(trial[k] - {1'b0, in_i.m})
                                   : trial[k][bfnl_pkg::MAG_W-1:0];
      data_d.lane[k].sh  = {in_i.lane[k].sh[bfnl_pkg::Q_W-2:0], fits[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    out_o       = data_q;
    out_o.valid = valid_q;
  end

endmodule

// ===== hw/rtl/bfnl_probe_cell.sv =====
module bfnl_probe_cell #(
  parameter int unsigned STEP = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  bfnl_pkg::probe_bus_t in_i,
  output bfnl_pkg::probe_bus_t out_o
);

  localparam int unsigned LEN   = 2 * STEP + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << bfnl_pkg::RECIP_SHIFT) + 64'(2 * LEN) - 64'd1) / 64'(2 * LEN);

  logic [bfnl_pkg::NUM_LANES-1:0][bfnl_pkg::Q_W-1:0]    l_new;
  logic [bfnl_pkg::NUM_LANES-1:0][bfnl_pkg::Q_W-1:0]    dev;
  logic [bfnl_pkg::NUM_LANES-1:0][bfnl_pkg::PROD_W-1:0] prod;
  logic [bfnl_pkg::NUM_LANES-1:0][bfnl_pkg::ERR_W-1:0]  err;
  logic [bfnl_pkg::ERR_W-1:0]                           err_max;
  logic                                                 take;

  bfnl_pkg::probe_mid_t mid_d, mid_q;
  logic                 mid_valid_q;
  bfnl_pkg::probe_bus_t res_d, res_q;
  logic                 res_valid_q;

  // first half: running product n*len kept modulo 2^17, distance to the code grid
  for (genvar k = 0; k < bfnl_pkg::NUM_LANES; k++) begin : g_dev
    assign l_new[k] = in_i.l[k] + {in_i.n[k][bfnl_pkg::Q_W-2:0], 1'b0};
    assign dev[k]   = l_new[k][bfnl_pkg::Q_W-1] ? {1'b0, l_new[k][bfnl_pkg::Q_W-2:0]}
                                                 : bfnl_pkg::Q_ONE - l_new[k];
  end

  always_comb begin
    mid_d           = '0;
    mid_d.valid     = in_i.valid;
    mid_d.zero      = in_i.zero;
    mid_d.n         = in_i.n;
    mid_d.l         = l_new;
    mid_d.best_err  = in_i.best_err;
    mid_d.best_step = in_i.best_step;
    for (int k = 0; k < bfnl_pkg::NUM_LANES; k++) begin
      // 2*|d| + len, divided by 2*len in the second half
      mid_d.num[k] = {dev[k], 1'b0} + bfnl_pkg::NUM_W'(LEN);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (en_i) begin
      mid_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= mid_d;
    end
  end

  // second half: reciprocal multiply gives the rounded error, then keep the best
  for (genvar k = 0; k < bfnl_pkg::NUM_LANES; k++) begin : g_err
    assign prod[k] = bfnl_pkg::PROD_W'(mid_q.num[k]) *
                     bfnl_pkg::PROD_W'(RECIP[bfnl_pkg::RECIP_W-1:0]);
    assign err[k]  = prod[k][bfnl_pkg::PROD_W-1:bfnl_pkg::RECIP_SHIFT];
  end

  always_comb begin
    err_max = err[0];
    for (int k = 1; k < bfnl_pkg::NUM_LANES; k++) begin
      if (err[k] > err_max) begin
        err_max = err[k];
      end
    end
  end

  assign take = (STEP == 1) || (err_max < mid_q.best_err);

  always_comb begin
    res_d.valid     = mid_q.valid;
    res_d.zero      = mid_q.zero;
    res_d.n         = mid_q.n;
    res_d.l         = mid_q.l;
    res_d.best_err  = take ? err_max : mid_q.best_err;
    res_d.best_step = take ? bfnl_pkg::STEP_W'(STEP) : mid_q.best_step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (en_i) begin
      res_valid_q <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    out_o       = res_q;
    out_o.valid = res_valid_q;
  end

endmodule

// ===== hw/rtl/best_fit_normal_length_search_core.sv =====
// Best-fit length search for 8-bit signed-normalized normals.
// Input channel: in_valid_i/in_ready_o carry normal_x_i, normal_y_i, normal_z_i
// (signed 16 bit, common scale). Output channel: out_valid_o/out_ready_i carry
// length_code_o (2*step+1), best_step_o and zero_vector_o, one result per input.
// A front stage takes magnitudes and the largest one, a 17-stage pipelined
// divider scales each component to Q1.16, then a chain of PROBE_STEPS cells,
// two register stages each, tries one probe length per cell and keeps the best.
// Throughput is one vector per cycle while the output is not stalled: every
// stage takes a new item in each cycle in which the pipeline advances.
// An all-zero vector returns length 255, step 127 with zero_vector_o set.
// The whole pipeline advances together; when the output holds a result that
// is not taken, every stage holds and in_ready_o drops until the transfer.
// Reset clears all stage valid bits; the block is ready right after reset.
`include "best_fit_normal_length_search_core_defines.svh"

module best_fit_normal_length_search_core #(
  parameter int unsigned PROBE_STEPS = bfnl_pkg::PROBE_STEPS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [bfnl_pkg::IN_W-1:0]   normal_x_i,
  input  logic signed [bfnl_pkg::IN_W-1:0]   normal_y_i,
  input  logic signed [bfnl_pkg::IN_W-1:0]   normal_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [bfnl_pkg::CODE_W-1:0]        length_code_o,
  output logic [bfnl_pkg::STEP_W-1:0]        best_step_o,
  output logic                               zero_vector_o
);

  logic                                                    en;
  logic [bfnl_pkg::NUM_LANES-1:0][bfnl_pkg::IN_W-1:0]      comp;
  logic [bfnl_pkg::NUM_LANES-1:0][bfnl_pkg::MAG_W-1:0]     mag;
  logic [bfnl_pkg::MAG_W-1:0]                              mag_max;
  logic [bfnl_pkg::NUM_LANES-1:0][2*bfnl_pkg::MAG_W-1:0]   numer;
  bfnl_pkg::div_bus_t                                      front_d, front_q;
  logic                                                    front_valid_q;
  bfnl_pkg::div_bus_t                                      div_bus [bfnl_pkg::Q_W+1];
  bfnl_pkg::probe_bus_t                                    chain [PROBE_STEPS+1];
  bfnl_pkg::probe_bus_t                                    last;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  assign comp[0] = normal_x_i;
  assign comp[1] = normal_y_i;
  assign comp[2] = normal_z_i;

  for (genvar k = 0; k < bfnl_pkg::NUM_LANES; k++) begin : g_mag
    assign mag[k]   = comp[k][bfnl_pkg::IN_W-1] ? bfnl_pkg::MAG_W'(-comp[k]) : comp[k];
    // |c|*65536 + m/2, quotient by m fits 17 bits
    assign numer[k] = {mag[k], {bfnl_pkg::MAG_W{1'b0}}} +
                      (2*bfnl_pkg::MAG_W)'(mag_max >> 1);
  end

  always_comb begin
    mag_max = mag[0];
    for (int k = 1; k < bfnl_pkg::NUM_LANES; k++) begin
      if (mag[k] > mag_max) begin
        mag_max = mag[k];
      end
    end
  end

  always_comb begin
    front_d       = '0;
    front_d.valid = in_valid_i;
    front_d.zero  = (mag_max == '0);
    front_d.m     = mag_max;
    for (int k = 0; k < bfnl_pkg::NUM_LANES; k++) begin
      front_d.lane[k].rem = {1'b0, numer[k][2*bfnl_pkg::MAG_W-1:bfnl_pkg::Q_W]};
      front_d.lane[k].sh  = numer[k][bfnl_pkg::Q_W-1:0];
      front_d.lane[k].neg = comp[k][bfnl_pkg::IN_W-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
    end else if (en) begin
      front_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      front_q <= front_d;
    end
  end

  always_comb begin
    div_bus[0]       = front_q;
    div_bus[0].valid = front_valid_q;
  end

  for (genvar i = 0; i < bfnl_pkg::Q_W; i++) begin : g_div
    bfnl_div_stage u_div_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .in_i   (div_bus[i]),
      .out_o  (div_bus[i+1])
    );
  end

  // signed normal, only its low 17 bits matter to the probe cells
  always_comb begin
    chain[0]           = '0;
    chain[0].valid     = div_bus[bfnl_pkg::Q_W].valid;
    chain[0].zero      = div_bus[bfnl_pkg::Q_W].zero;
    for (int k = 0; k < bfnl_pkg::NUM_LANES; k++) begin
      chain[0].n[k] = div_bus[bfnl_pkg::Q_W].lane[k].neg
                      ? bfnl_pkg::Q_W'(~div_bus[bfnl_pkg::Q_W].lane[k].sh + 1'b1)
                      : div_bus[bfnl_pkg::Q_W].lane[k].sh;
      chain[0].l[k] = chain[0].n[k];
    end
  end

  for (genvar s = 0; s < PROBE_STEPS; s++) begin : g_cell
    bfnl_probe_cell #(
      .STEP (s + 1)
    ) u_probe_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .in_i   (chain[s]),
      .out_o  (chain[s+1])
    );
  end

  assign last          = chain[PROBE_STEPS];
  assign out_valid_o   = last.valid;
  assign zero_vector_o = last.zero;
  assign best_step_o   = last.zero ? bfnl_pkg::ZERO_STEP : last.best_step;
  assign length_code_o = last.zero ? bfnl_pkg::ZERO_CODE : {last.best_step, 1'b1};

  `BFNL_ASSERT_NOW(a_zero_result, out_valid_o && zero_vector_o,
                   length_code_o == bfnl_pkg::ZERO_CODE && best_step_o == bfnl_pkg::ZERO_STEP,
                   "zero vector result malformed")
  `BFNL_ASSERT_NOW(a_step_range, out_valid_o && !zero_vector_o,
                   best_step_o != '0 && 32'(best_step_o) <= PROBE_STEPS,
                   "best step out of range")
  `BFNL_ASSERT_NEXT(a_stall_freezes, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(last.best_err) && $stable(div_bus[1].m),
                    "pipeline moved during output stall")

endmodule
